// ===== rtl/stt_pkg.sv =====
// shared types, codes and constants of the software timer table
package stt_pkg;

	localparam int NUM_TIMERS_DEF = 16;
	localparam int MAX_RESULTS    = 16;

	// command codes
	localparam logic [2:0] CMD_ALLOC = 3'd0;
	localparam logic [2:0] CMD_FREE  = 3'd1;
	localparam logic [2:0] CMD_INIT  = 3'd2;
	localparam logic [2:0] CMD_SET   = 3'd3;
	localparam logic [2:0] CMD_TICK  = 3'd4;

	// result kinds
	localparam logic KIND_ALLOC  = 1'b0;
	localparam logic KIND_EXPIRE = 1'b1;

	typedef enum logic [1:0] {
		ST_FREE  = 2'd0,
		ST_ALLOC = 2'd1,
		ST_RUN   = 2'd2
	} status_t;

	// one table entry as held in the slot memory
	typedef struct packed {
		status_t     status;
		logic [31:0] deadline;
		logic [7:0]  payload;
		logic [3:0]  queue;
	} entry_t;

	typedef struct packed {
		logic       kind;
		logic [3:0] slot_out;
		logic       ok;
		logic [7:0] byte_out;
		logic [3:0] queue_out;
		logic       last;
	} result_t;

	// result handoff from the controller to the output stage
	typedef struct packed {
		logic    push;
		result_t res;
	} push_t;

endpackage

// ===== rtl/stt_if.sv =====
// request and response channel interfaces of the software timer table
interface stt_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [3:0]  slot;
	logic [31:0] delay;
	logic [7:0]  payload;
	logic [3:0]  dest_queue;

	modport source (output valid, cmd, slot, delay, payload, dest_queue, input ready);
	modport sink (input valid, cmd, slot, delay, payload, dest_queue, output ready);
endinterface

interface stt_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [3:0] slot_out;
	logic       ok;
	logic [7:0] byte_out;
	logic [3:0] queue_out;
	logic       last;

	modport source (output valid, kind, slot_out, ok, byte_out, queue_out, last, input ready);
	modport sink (input valid, kind, slot_out, ok, byte_out, queue_out, last, output ready);
endinterface

// ===== rtl/stt_ram.sv =====
// generic single write port ram with registered read
module stt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/stt_out.sv =====
// output register between the controller and the response channel
module stt_out import stt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	output logic      out_free,
	stt_out_if.source rsp
);

	logic    out_vld_q;
	result_t res_q;

	assign out_free = !out_vld_q || rsp.ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push.push) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// payload word
	always_ff @(posedge clk) begin
		if (push.push) begin
			res_q <= push.res;
		end
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.kind      = res_q.kind;
	assign rsp.slot_out  = res_q.slot_out;
	assign rsp.ok        = res_q.ok;
	assign rsp.byte_out  = res_q.byte_out;
	assign rsp.queue_out = res_q.queue_out;
	assign rsp.last      = res_q.last;

endmodule

// ===== rtl/stt_ctrl.sv =====
// command sequencer: read-modify-write of the slot memory and the slot scan
module stt_ctrl import stt_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	stt_in_if.sink   req,
	input  logic     out_free,
	output push_t    push,
	output logic     ram_we,
	output logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] ram_waddr,
	output entry_t   ram_wdata,
	output logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] ram_raddr,
	input  entry_t   ram_rdata
);

	localparam int IW   = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;
	localparam int CW   = $clog2(NUM_TIMERS + 1);
	localparam int CNTW = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMD,
		S_SCAN
	} state_t;

	state_t                state_q;
	logic [2:0]            cmd_q;
	logic [31:0]           delay_q;
	logic [7:0]            pay_q;
	logic [3:0]            dq_q;
	logic [31:0]           tc_q;
	logic [NUM_TIMERS-1:0] vld_q;
	logic [CW-1:0]         rd_cnt_q;
	logic                  proc_vld_s1;
	logic [IW-1:0]         proc_idx_s1;
	logic                  pend_vld_q;
	logic [IW-1:0]         pend_idx_q;
	logic [7:0]            pend_pay_q;
	logic [3:0]            pend_dq_q;
	logic [CNTW-1:0]       cnt_q;

	logic    accept;
	logic    in_range;
	logic    is_alloc;
	status_t cur_st;
	logic    hit;
	logic    need_push;
	logic    stall;
	logic    more;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign in_range  = 32'(req.slot) < NUM_TIMERS;
	assign is_alloc  = (cmd_q == CMD_ALLOC);
	assign more      = rd_cnt_q < CW'(NUM_TIMERS);

	// effective status: an entry without a valid bit is free
	assign cur_st = vld_q[proc_idx_s1] ? ram_rdata.status : ST_FREE;

	// scan decision for the entry now at the memory output
	always_comb begin
		hit       = 1'b0;
		need_push = 1'b0;
		if (state_q == S_SCAN) begin
			if (proc_vld_s1) begin
				if (is_alloc) begin
					hit       = (cur_st == ST_FREE);
					need_push = hit;
				end else begin
					hit = (cur_st == ST_RUN) && (ram_rdata.deadline <= tc_q)
						&& (cnt_q < CNTW'(MAX_RESULTS));
					need_push = hit && pend_vld_q;
				end
			end else begin
				need_push = is_alloc || pend_vld_q;
			end
		end
	end

	assign stall = need_push && !out_free;

	// result word
	always_comb begin
		push.push = need_push && !stall;
		if (is_alloc) begin
			push.res.kind      = KIND_ALLOC;
			push.res.slot_out  = proc_vld_s1 ? 4'(proc_idx_s1) : 4'd0;
			push.res.ok        = proc_vld_s1;
			push.res.byte_out  = 8'd0;
			push.res.queue_out = 4'd0;
			push.res.last      = 1'b1;
		end else begin
			push.res.kind      = KIND_EXPIRE;
			push.res.slot_out  = 4'(pend_idx_q);
			push.res.ok        = 1'b1;
			push.res.byte_out  = pend_pay_q;
			push.res.queue_out = pend_dq_q;
			push.res.last      = !proc_vld_s1;
		end
	end

	// memory read address
	always_comb begin
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = (req.cmd == CMD_ALLOC || req.cmd == CMD_TICK) ?
					IW'(0) : IW'(req.slot);
			end
			S_SCAN: ram_raddr = stall ? proc_idx_s1 : rd_cnt_q[IW-1:0];
			default: ram_raddr = proc_idx_s1;
		endcase
	end

	// memory write back
	always_comb begin
		ram_waddr = proc_idx_s1;
		ram_wdata = ram_rdata;
		ram_we    = 1'b0;
		if (state_q == S_CMD) begin
			ram_we = 1'b1;
			if (cmd_q == CMD_SET) begin
				ram_wdata.status   = ST_RUN;
				ram_wdata.deadline = delay_q + tc_q;
			end else begin
				ram_wdata.status  = cur_st;
				ram_wdata.payload = pay_q;
				ram_wdata.queue   = dq_q;
			end
		end else if (hit && !stall) begin
			ram_we           = 1'b1;
			ram_wdata.status = ST_ALLOC;
		end
	end

	// sequencer state and scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= CMD_ALLOC;
			tc_q        <= 32'd0;
			vld_q       <= '0;
			rd_cnt_q    <= '0;
			proc_vld_s1 <= 1'b0;
			proc_idx_s1 <= '0;
			pend_vld_q  <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= req.cmd;
						if (req.cmd == CMD_ALLOC || req.cmd == CMD_TICK) begin
							state_q     <= S_SCAN;
							proc_vld_s1 <= 1'b1;
							proc_idx_s1 <= '0;
							rd_cnt_q    <= CW'(1);
							cnt_q       <= '0;
							pend_vld_q  <= 1'b0;
							if (req.cmd == CMD_TICK) begin
								tc_q <= tc_q + 32'd1;
							end
						end else if ((req.cmd == CMD_INIT || req.cmd == CMD_SET) && in_range) begin
							state_q     <= S_CMD;
							proc_idx_s1 <= IW'(req.slot);
						end else if (req.cmd == CMD_FREE && in_range) begin
							vld_q[IW'(req.slot)] <= 1'b0;
						end
					end
				end
				S_CMD: begin
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (!stall) begin
						if (!proc_vld_s1 || (is_alloc && hit)) begin
							state_q     <= S_IDLE;
							proc_vld_s1 <= 1'b0;
							pend_vld_q  <= 1'b0;
						end else begin
							if (hit) begin
								pend_vld_q <= 1'b1;
								cnt_q      <= cnt_q + CNTW'(1);
							end
							proc_vld_s1 <= more;
							if (more) begin
								proc_idx_s1 <= rd_cnt_q[IW-1:0];
								rd_cnt_q    <= rd_cnt_q + CW'(1);
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command fields and pending expiry
	always_ff @(posedge clk) begin
		if (accept) begin
			delay_q <= req.delay;
			pay_q   <= req.payload;
			dq_q    <= req.dest_queue;
		end
		if (state_q == S_SCAN && !is_alloc && hit && !stall) begin
			pend_idx_q <= proc_idx_s1;
			pend_pay_q <= ram_rdata.payload;
			pend_dq_q  <= ram_rdata.queue;
		end
	end

`ifndef SYNTH
	// a held expiry exists only during a scan
	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> state_q == S_SCAN)
		else $error("pending expiry outside a scan");

	// never overwrite a result the output stage still holds
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> out_free)
		else $error("result pushed into a full output stage");

	// expiry count per tick stays bounded
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(MAX_RESULTS))
		else $error("too many expiries in one tick");

	// the final word of a command ends the scan
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(push.push && push.res.last) |=> state_q == S_IDLE)
		else $error("scan continues after final word");
`endif

endmodule

// ===== rtl/software_timer_table_top.sv =====
// top level of the software timer table
// A table of NUM_TIMERS software timers driven by alloc, free, init, set time and
// tick commands on the req channel; alloc replies and timer expiries leave on the
// rsp channel, with last set on the final word a command sends. All slot state
// lives in one slot memory with a single read port, so an alloc or tick walks
// the slots one per cycle unless the response side holds a word untaken; init
// and set time read and write back one slot, and free clears its valid bit.
// The status of each slot is cleared at reset through per-slot valid bits, so
// no clearing pass is needed.
module software_timer_table_top import stt_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	stt_in_if.sink    req,
	stt_out_if.source rsp
);

	localparam int IW = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;

	push_t         push;
	logic          out_free;
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [IW-1:0] ram_raddr;
	entry_t        ram_wdata;
	entry_t        ram_rdata;
	logic [$bits(entry_t)-1:0] rdata_raw;

	assign ram_rdata = entry_t'(rdata_raw);

	// slot memory
	stt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (NUM_TIMERS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata_raw)
	);

	// command sequencer
	stt_ctrl #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_free  (out_free),
		.push      (push),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// response register
	stt_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.out_free (out_free),
		.rsp      (rsp)
	);

endmodule
